### src/ftc_pkg.sv
// ----------------------------------------------------------------------------
// ftc_pkg
// types and constants shared by the flow table cache
// ----------------------------------------------------------------------------
package ftc_pkg;

    localparam int KEY_W = 104;
    localparam int HOST_W = 32;
    localparam int TIME_W = 32;
    localparam int LIFE_W = 17;
    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 17'd600;

    typedef enum logic [2:0] {
        ST_REFRESHED = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_HIT       = 3'd4,
        ST_MISS      = 3'd5
    } status_t;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_LOOKUP = 1'b1
    } action_t;

    typedef struct packed {
        logic        action;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  protocol;
        logic [31:0] host_in;
        logic [31:0] now_seconds;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] host_out;
    } out_beat_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [HOST_W-1:0] host;
        logic [TIME_W-1:0] expiry;
    } way_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_OUT
    } state_t;

endpackage

### src/flow_tuple_host_cache_core.sv
// ----------------------------------------------------------------------------
// flow_tuple_host_cache_core
// hashed five-tuple flow table with aging, bucket read-modify-write
// ----------------------------------------------------------------------------
// path: input beat to result beat through the read, decide and output states
// one item at a time, set by the single bucket read-modify-write; no new input
// until the result beat leaves; reset: valid bits cleared by a sweep of all
// BUCKETS rows; no input accepted until it ends; lifetime resets to 600
module flow_tuple_host_cache_core #(
    parameter int BUCKETS = 1024,
    parameter int WAYS = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  ftc_pkg::in_beat_t      in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ftc_pkg::out_beat_t     out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [16:0]            cfg_data
);

    localparam int AW = $clog2(BUCKETS);
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    ftc_pkg::state_t state_reg, state_next;
    ftc_pkg::in_beat_t item_reg;
    logic [AW-1:0] bucket_reg;
    logic [ftc_pkg::LIFE_W-1:0] life_reg;
    ftc_pkg::out_beat_t res_reg, res_next;
    logic clr_done;

    ftc_pkg::way_t [WAYS-1:0] rd_ways, wr_ways;
    logic [WAYS-1:0] rd_valid, wr_valid;
    logic wr_en;

    logic [31:0] hash;
    logic [31:0] fold;
    logic [AW-1:0] bucket_in;
    logic accept;

    assign hash = in_data.source_address ^ in_data.dest_address
                ^ {in_data.source_port, in_data.dest_port} ^ {24'd0, in_data.protocol};
    assign fold = hash ^ {16'd0, hash[31:16]};
    assign bucket_in = fold[AW-1:0];
    assign accept = in_valid && !in_stall;

    ftc_bucket_mem #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_bucket (
        .clk     (clk),
        .rd_addr (bucket_in),
        .rd_data (rd_ways),
        .wr_en   (wr_en),
        .wr_addr (bucket_reg),
        .wr_data (wr_ways)
    );

    ftc_valid_mem #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_valid (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr_done (clr_done),
        .rd_addr  (bucket_in),
        .rd_data  (rd_valid),
        .wr_en    (wr_en),
        .wr_addr  (bucket_reg),
        .wr_data  (wr_valid)
    );

    // registered memory output, decided in the following cycle
    ftc_pkg::way_t [WAYS-1:0] ways_reg;
    logic [WAYS-1:0] vals_reg;
    logic [ftc_pkg::KEY_W-1:0] key;
    logic [32:0] exp_sum;
    logic [31:0] exp_val;

    assign key = {item_reg.source_address, item_reg.dest_address,
                  item_reg.source_port, item_reg.dest_port, item_reg.protocol};
    assign exp_sum = {1'b0, item_reg.now_seconds} + {16'd0, life_reg};
    assign exp_val = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftc_pkg::S_IDLE;
            life_reg <= ftc_pkg::LIFETIME_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                life_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
            bucket_reg <= bucket_in;
        end
        if (state_reg == ftc_pkg::S_READ)
        begin
            ways_reg <= rd_ways;
            vals_reg <= rd_valid;
        end
        if (state_reg == ftc_pkg::S_DECIDE)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        logic found;
        logic spare_found;
        logic [WW-1:0] m;
        logic [WW-1:0] sp;
        found = 1'b0;
        spare_found = 1'b0;
        m = '0;
        sp = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && vals_reg[w] && ways_reg[w].key == key)
            begin
                found = 1'b1;
                m = WW'(w);
            end
            if (!spare_found && (!vals_reg[w] || ways_reg[w].expiry < item_reg.now_seconds))
            begin
                spare_found = 1'b1;
                sp = WW'(w);
            end
        end
        wr_ways = ways_reg;
        wr_valid = vals_reg;
        wr_en = 1'b0;
        res_next.host_out = '0;
        if (item_reg.action == ftc_pkg::ACT_LOOKUP)
        begin
            if (found && ways_reg[m].expiry > item_reg.now_seconds)
            begin
                res_next.status = ftc_pkg::ST_HIT;
                res_next.host_out = ways_reg[m].host;
            end
            else
            begin
                res_next.status = ftc_pkg::ST_MISS;
            end
        end
        else if (item_reg.host_in == '0)
        begin
            res_next.status = ftc_pkg::ST_IGNORED;
        end
        else if (found)
        begin
            res_next.status = ftc_pkg::ST_REFRESHED;
            wr_ways[m].host = item_reg.host_in;
            wr_ways[m].expiry = exp_val;
            wr_en = (state_reg == ftc_pkg::S_DECIDE);
        end
        else if (spare_found)
        begin
            res_next.status = ftc_pkg::ST_INSERTED;
            wr_ways[sp].key = key;
            wr_ways[sp].host = item_reg.host_in;
            wr_ways[sp].expiry = exp_val;
            wr_valid[sp] = 1'b1;
            wr_en = (state_reg == ftc_pkg::S_DECIDE);
        end
        else
        begin
            res_next.status = ftc_pkg::ST_DROPPED;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ftc_pkg::S_IDLE:   if (accept) state_next = ftc_pkg::S_READ;
            ftc_pkg::S_READ:   state_next = ftc_pkg::S_DECIDE;
            ftc_pkg::S_DECIDE: state_next = ftc_pkg::S_OUT;
            ftc_pkg::S_OUT:    if (!out_stall) state_next = ftc_pkg::S_IDLE;
            default:           state_next = ftc_pkg::S_IDLE;
        endcase
    end

    assign in_stall = !(state_reg == ftc_pkg::S_IDLE && clr_done);
    assign out_valid = (state_reg == ftc_pkg::S_OUT);
    assign out_data = res_reg;
    assign cfg_ready = 1'b1;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !out_valid && in_stall) else $error("overlap of items");
    a_write_decide: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == ftc_pkg::S_DECIDE) else $error("stray write");
    a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ftc_pkg::S_DECIDE |=> out_valid) else $error("missing result");

endmodule

### src/ftc_bucket_mem.sv
// ----------------------------------------------------------------------------
// ftc_bucket_mem
// bucket store: one row per bucket holding all ways, registered-read latency
// ----------------------------------------------------------------------------
module ftc_bucket_mem #(
    parameter int BUCKETS = 1024,
    parameter int WAYS = 4,
    localparam int AW = $clog2(BUCKETS)
) (
    input  logic                        clk,
    input  logic [AW-1:0]               rd_addr,
    output ftc_pkg::way_t [WAYS-1:0]    rd_data,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  ftc_pkg::way_t [WAYS-1:0]    wr_data
);

    ftc_pkg::way_t [WAYS-1:0] mem [BUCKETS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### src/ftc_valid_mem.sv
// ----------------------------------------------------------------------------
// ftc_valid_mem
// per-bucket valid bits, cleared by a sweep after reset
// ----------------------------------------------------------------------------
module ftc_valid_mem #(
    parameter int BUCKETS = 1024,
    parameter int WAYS = 4,
    localparam int AW = $clog2(BUCKETS)
) (
    input  logic             clk,
    input  logic             rst_n,
    output logic             clr_done,
    input  logic [AW-1:0]    rd_addr,
    output logic [WAYS-1:0]  rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WAYS-1:0]  wr_data
);

    logic [WAYS-1:0] mem [BUCKETS];
    logic [AW-1:0]   clr_addr_reg;
    logic            clr_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (!clr_done_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(BUCKETS - 1))
            begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clr_done_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign clr_done = clr_done_reg;

endmodule
